// ----- src/fwupd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the firmware update session controller.
// Depends on nothing; every other file imports it.
package fwupd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Input operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_BYTE = 2'd0;
    localparam t_op OP_PKT  = 2'd1;
    localparam t_op OP_TICK = 2'd2;

    // Reply codes
    typedef logic [2:0] t_reply;
    localparam t_reply RPL_NONE   = 3'd0;
    localparam t_reply RPL_SYNCED = 3'd1;
    localparam t_reply RPL_ACK    = 3'd2;
    localparam t_reply RPL_NACK   = 3'd3;
    localparam t_reply RPL_DONE   = 3'd4;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TIMEOUT_TICKS = 3'd0;
    localparam t_cfg_idx CFG_MAX_IMAGE     = 3'd1;
    localparam t_cfg_idx CFG_DEVICE_IDENT  = 3'd2;
    localparam t_cfg_idx CFG_REQUEST_LEN   = 3'd3;
    localparam t_cfg_idx CFG_SIZE_PKT_LEN  = 3'd4;
    localparam t_cfg_idx CFG_REQUEST_CODE  = 3'd5;
    localparam t_cfg_idx CFG_SIZE_CODE     = 3'd6;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd2000;
    localparam logic [23:0] RST_MAX_IMAGE     = 24'd65536;
    localparam logic [7:0]  RST_DEVICE_IDENT  = 8'd0;
    localparam logic [7:0]  RST_REQUEST_LEN   = 8'd1;
    localparam logic [7:0]  RST_SIZE_PKT_LEN  = 8'd5;
    localparam logic [7:0]  RST_REQUEST_CODE  = 8'd0;
    localparam logic [7:0]  RST_SIZE_CODE     = 8'd1;

    // "F103" as it sits in the four-byte window, oldest byte lowest
    localparam logic [31:0] SYNC_PATTERN = 32'h3330_3146;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [23:0] max_image_bytes;
        logic [7:0]  device_ident;
        logic [7:0]  request_len;
        logic [7:0]  size_pkt_len;
        logic [7:0]  request_code;
        logic [7:0]  size_code;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  rx_byte;
        logic        pkt_is_data;
        logic [7:0]  pkt_length;
        logic [7:0]  pkt_first_byte;
        logic [31:0] pkt_size_word;
    } t_in_item;

    typedef struct packed {
        t_reply      reply;
        logic [7:0]  reply_payload;
        logic        erase_app;
        logic        load_iv;
        logic        write_flash;
        logic        decrypt;
        logic [23:0] write_offset;
        logic [7:0]  write_length;
        logic        finished;
    } t_out_item;

endpackage

// ----- src/fwupd_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on fwupd_pkg.
interface fwupd_in_if;
    import fwupd_pkg::*;
    logic        valid;
    logic        ready;
    t_op         op;
    logic [7:0]  rx_byte;
    logic        pkt_is_data;
    logic [7:0]  pkt_length;
    logic [7:0]  pkt_first_byte;
    logic [31:0] pkt_size_word;

    modport source (output valid, op, rx_byte, pkt_is_data, pkt_length, pkt_first_byte,
                    pkt_size_word, input ready);
    modport sink (input valid, op, rx_byte, pkt_is_data, pkt_length, pkt_first_byte,
                  pkt_size_word, output ready);
endinterface

interface fwupd_res_if;
    import fwupd_pkg::*;
    logic        valid;
    logic        ready;
    t_reply      reply;
    logic [7:0]  reply_payload;
    logic        erase_app;
    logic        load_iv;
    logic        write_flash;
    logic        decrypt;
    logic [23:0] write_offset;
    logic [7:0]  write_length;
    logic        finished;

    modport source (output valid, reply, reply_payload, erase_app, load_iv, write_flash,
                    decrypt, write_offset, write_length, finished, input ready);
    modport sink (input valid, reply, reply_payload, erase_app, load_iv, write_flash,
                  decrypt, write_offset, write_length, finished, output ready);
endinterface

// ----- src/firmware_update_session_fsm.sv -----
`timescale 1ns / 1ps
// Firmware update session controller, top level.
// An item is held in the input register, then any result in the result register.
// One item per cycle while the sink is ready: the input register refills as the
// session logic takes its item, the result register frees as the sink takes one.
// Reset (i_rst_n low, synchronous): session back to sync wait, counters and window
// cleared, configuration registers to their defaults, both channels empty.
module firmware_update_session_fsm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  fwupd_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [fwupd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fwupd_in_if.sink                         i_item,
    fwupd_res_if.source                      o_res
);
    import fwupd_pkg::*;

    t_cfg      cfg;
    t_in_item  in_item;
    t_in_item  held_item;
    t_out_item res_next;
    t_out_item res_held;
    logic      in_ready;
    logic      held_valid;
    logic      res_next_valid;
    logic      out_free;
    logic      go;
    logic      out_valid;

    // Gather the input channel into one item
    assign in_item = '{
        op:             i_item.op,
        rx_byte:        i_item.rx_byte,
        pkt_is_data:    i_item.pkt_is_data,
        pkt_length:     i_item.pkt_length,
        pkt_first_byte: i_item.pkt_first_byte,
        pkt_size_word:  i_item.pkt_size_word
    };
    assign i_item.ready = in_ready;

    // Advance the held item whenever the result register can take its result
    assign go = held_valid && out_free;

    fwupd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    fwupd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .i_take  (go),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    fwupd_session u_session (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (held_item),
        .i_cfg       (cfg),
        .o_res_valid (res_next_valid),
        .o_res       (res_next)
    );

    fwupd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go),
        .i_res_valid (res_next_valid),
        .i_res       (res_next),
        .i_ready     (o_res.ready),
        .o_free      (out_free),
        .o_valid     (out_valid),
        .o_res       (res_held)
    );

    // Spread the held result onto the output channel
    assign o_res.valid         = out_valid;
    assign o_res.reply         = res_held.reply;
    assign o_res.reply_payload = res_held.reply_payload;
    assign o_res.erase_app     = res_held.erase_app;
    assign o_res.load_iv       = res_held.load_iv;
    assign o_res.write_flash   = res_held.write_flash;
    assign o_res.decrypt       = res_held.decrypt;
    assign o_res.write_offset  = res_held.write_offset;
    assign o_res.write_length  = res_held.write_length;
    assign o_res.finished      = res_held.finished;

endmodule

// ----- src/fwupd_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register bank, written through a plain index/data port.
// Depends on fwupd_pkg.
module fwupd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  fwupd_pkg::t_cfg_idx                 i_idx,
    input  logic [fwupd_pkg::CFG_DATA_W-1:0]    i_data,
    output fwupd_pkg::t_cfg                     o_cfg
);
    import fwupd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks   <= RST_TIMEOUT_TICKS;
            r_cfg.max_image_bytes <= RST_MAX_IMAGE;
            r_cfg.device_ident    <= RST_DEVICE_IDENT;
            r_cfg.request_len     <= RST_REQUEST_LEN;
            r_cfg.size_pkt_len    <= RST_SIZE_PKT_LEN;
            r_cfg.request_code    <= RST_REQUEST_CODE;
            r_cfg.size_code       <= RST_SIZE_CODE;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks   <= i_data[15:0];
                CFG_MAX_IMAGE:     r_cfg.max_image_bytes <= i_data[23:0];
                CFG_DEVICE_IDENT:  r_cfg.device_ident    <= i_data[7:0];
                CFG_REQUEST_LEN:   r_cfg.request_len     <= i_data[7:0];
                CFG_SIZE_PKT_LEN:  r_cfg.size_pkt_len    <= i_data[7:0];
                CFG_REQUEST_CODE:  r_cfg.request_code    <= i_data[7:0];
                CFG_SIZE_CODE:     r_cfg.size_code       <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/fwupd_in_reg.sv -----
`timescale 1ns / 1ps
// Input register: holds one accepted item until the session logic takes it.
// Depends on fwupd_pkg.
module fwupd_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fwupd_pkg::t_in_item i_item,
    input  logic                i_take,
    output logic                o_valid,
    output fwupd_pkg::t_in_item o_item
);
    import fwupd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Refill in the same cycle the held item moves on
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- src/fwupd_session.sv -----
`timescale 1ns / 1ps
// Session state machine: sync window, timeout counter, size and offset tracking.
// Depends on fwupd_pkg.
module fwupd_session (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  fwupd_pkg::t_in_item  i_item,
    input  fwupd_pkg::t_cfg      i_cfg,
    output logic                 o_res_valid,
    output fwupd_pkg::t_out_item o_res
);
    import fwupd_pkg::*;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_REQUEST,
        PH_SIZE,
        PH_IV,
        PH_DATA,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [23:0] r_win, n_win;      // last three raw bytes, newest highest
    logic [15:0] r_idle, n_idle;
    logic [23:0] r_size, n_size;
    logic [23:0] r_done, n_done;

    logic [15:0] idle_inc;
    logic [31:0] window;
    logic [24:0] sum;
    logic [23:0] done_sat;
    logic        timed_out;

    assign idle_inc  = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
    assign timed_out = idle_inc >= i_cfg.timeout_ticks;
    assign window    = {i_item.rx_byte, r_win};
    assign sum       = {1'b0, r_done} + {17'd0, i_item.pkt_length};
    assign done_sat  = sum[24] ? 24'hFF_FFFF : sum[23:0];

    always_comb begin
        n_phase     = r_phase;
        n_win       = r_win;
        n_idle      = r_idle;
        n_size      = r_size;
        n_done      = r_done;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_phase != PH_DONE) begin
            unique case (i_item.op)
                OP_TICK: begin
                    if (r_phase == PH_SYNC || r_phase == PH_REQUEST || r_phase == PH_SIZE) begin
                        n_idle = idle_inc;
                        if (timed_out) begin
                            // sync timeout ends with no reply code, later ones nack
                            n_phase        = PH_DONE;
                            o_res_valid    = 1'b1;
                            o_res.finished = 1'b1;
                            o_res.reply    = (r_phase == PH_SYNC) ? RPL_NONE : RPL_NACK;
                        end
                    end
                end
                OP_BYTE: begin
                    if (r_phase == PH_SYNC) begin
                        n_win = window[31:8];
                        if (window == SYNC_PATTERN) begin
                            n_idle              = '0;
                            n_phase             = PH_REQUEST;
                            o_res_valid         = 1'b1;
                            o_res.reply         = RPL_SYNCED;
                            o_res.reply_payload = i_cfg.device_ident;
                        end
                    end
                end
                OP_PKT: begin
                    unique case (r_phase)
                        PH_REQUEST: begin
                            o_res_valid = 1'b1;
                            if (i_item.pkt_length != i_cfg.request_len || i_item.pkt_is_data
                                || i_item.pkt_first_byte != i_cfg.request_code) begin
                                n_phase        = PH_DONE;
                                o_res.reply    = RPL_NACK;
                                o_res.finished = 1'b1;
                            end else begin
                                n_idle      = '0;
                                n_phase     = PH_SIZE;
                                o_res.reply = RPL_ACK;
                            end
                        end
                        PH_SIZE: begin
                            o_res_valid = 1'b1;
                            if (i_item.pkt_length != i_cfg.size_pkt_len || i_item.pkt_is_data
                                || i_item.pkt_first_byte != i_cfg.size_code
                                || i_item.pkt_size_word > {8'd0, i_cfg.max_image_bytes}) begin
                                n_phase        = PH_DONE;
                                o_res.reply    = RPL_NACK;
                                o_res.finished = 1'b1;
                            end else begin
                                n_size      = i_item.pkt_size_word[23:0];
                                n_idle      = '0;
                                n_phase     = PH_IV;
                                o_res.reply = RPL_ACK;
                            end
                        end
                        PH_IV, PH_DATA: begin
                            o_res_valid = 1'b1;
                            if (!i_item.pkt_is_data) begin
                                n_phase        = PH_DONE;
                                o_res.reply    = RPL_NACK;
                                o_res.finished = 1'b1;
                            end else begin
                                n_done             = done_sat;
                                o_res.write_flash  = 1'b1;
                                o_res.write_offset = r_done;
                                o_res.write_length = i_item.pkt_length;
                                if (r_phase == PH_IV) begin
                                    // IV packet: erase first, load the vector, store it
                                    n_phase         = PH_DATA;
                                    o_res.reply     = RPL_ACK;
                                    o_res.erase_app = 1'b1;
                                    o_res.load_iv   = 1'b1;
                                end else begin
                                    o_res.decrypt = 1'b1;
                                    if (done_sat < r_size) begin
                                        o_res.reply = RPL_ACK;
                                    end else begin
                                        n_phase        = PH_DONE;
                                        o_res.reply    = RPL_DONE;
                                        o_res.finished = 1'b1;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_win   <= '0;
            r_idle  <= '0;
            r_size  <= '0;
            r_done  <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_win   <= n_win;
            r_idle  <= n_idle;
            r_size  <= n_size;
            r_done  <= n_done;
        end
    end

endmodule

// ----- src/fwupd_out_reg.sv -----
`timescale 1ns / 1ps
// Result register: holds a finished result until the sink takes it.
// Depends on fwupd_pkg.
module fwupd_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_res_valid,
    input  fwupd_pkg::t_out_item i_res,
    input  logic                 i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output fwupd_pkg::t_out_item o_res
);
    import fwupd_pkg::*;

    logic      r_valid;
    t_out_item r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- src/fwupd_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the session controller, bound to the top level.
// Depends on fwupd_pkg.
module fwupd_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input fwupd_pkg::t_out_item  i_res
);
    import fwupd_pkg::*;

    logic r_ended;

    // Track that a session-ending result has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else if (i_res_valid && i_res_ready && i_res.finished) begin
            r_ended <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_no_result_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> !i_res_valid)
        else $error("result after the session ended");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("stalled result changed");

    a_no_write_no_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res.write_flash |->
            i_res.write_offset == '0 && i_res.write_length == '0 && !i_res.erase_app)
        else $error("offset or length without a flash write");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.reply == RPL_DONE |->
            i_res.finished && i_res.write_flash && i_res.decrypt)
        else $error("update done without final write");

endmodule

bind firmware_update_session_fsm fwupd_chk u_fwupd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (res_held)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the firmware update session controller: random and directed
// bytes, packets and ticks against a cycle-free session predictor. Needs fwupd_pkg,
// the channel interfaces and the firmware_update_session_fsm top level.
module testbench;
    import fwupd_pkg::*;

    localparam int       CYCLE_LIMIT = 300_000;
    localparam int       ITEM_TARGET = 1150;
    // Op code 3 is not decoded by the block and must be swallowed silently
    localparam t_op      OP_RESERVED = 2'd3;
    // Index 7 has no register behind it; a write there changes nothing
    localparam t_cfg_idx CFG_UNUSED  = 3'd7;

    typedef enum logic [2:0] {
        SES_SYNC, SES_REQUEST, SES_SIZE, SES_IV, SES_DATA, SES_DONE
    } t_session_phase;

    // How this run's single session is brought to its end
    typedef enum logic [2:0] {
        END_DONE, END_DATA_NACK, END_IV_NACK, END_SYNC_TIMEOUT,
        END_REQ_TIMEOUT, END_REQ_BAD, END_SIZE_TIMEOUT, END_SIZE_BAD
    } t_session_end;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fwupd_in_if  item_ch ();
    fwupd_res_if res_ch ();

    firmware_update_session_fsm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_res      (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus waiting for the driver, and replies the predictor says are still owed
    t_in_item  items_to_send[$];
    t_out_item replies_due[$];

    int         fail_count     = 0;
    int         cycle_count    = 0;
    int         accepted_count = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    t_idle_mode idle_mode      = IDLE_NONE;

    // Predictor copy of the configuration and of the session state
    t_cfg           cfg_shadow;
    t_session_phase sess_phase;
    logic [31:0]    sync_win;
    logic [15:0]    idle_cnt;
    logic [23:0]    image_len;
    logic [23:0]    done_cnt;

    // Generator-side bookkeeping: window contents and ticks since the last progress
    logic [31:0] gen_win   = '0;
    int          gen_ticks = 0;

    // ------------------------------------------------------------------
    // Session predictor
    // ------------------------------------------------------------------
    function automatic void abort_session(output t_out_item r);
        sess_phase = SES_DONE;
        r          = '0;
        r.reply    = RPL_NACK;
        r.finished = 1'b1;
    endfunction

    // Advance the running offset, saturating at the top of the 24-bit space
    function automatic void add_written(input logic [7:0] len);
        logic [24:0] sum;
        sum      = {1'b0, done_cnt} + {17'd0, len};
        done_cnt = sum[24] ? 24'hFF_FFFF : sum[23:0];
    endfunction

    // Apply one accepted item; return 1 with the reply in r when the item causes one
    function automatic bit advance_session(input t_in_item it, output t_out_item r);
        logic [23:0] offs;
        r = '0;
        if (sess_phase == SES_DONE)
            return 1'b0;
        case (it.op)
            OP_TICK: begin
                // Ticks only matter while waiting for sync, request or size
                if (sess_phase != SES_SYNC && sess_phase != SES_REQUEST &&
                    sess_phase != SES_SIZE)
                    return 1'b0;
                if (idle_cnt != 16'hFFFF)
                    idle_cnt++;
                if (idle_cnt < cfg_shadow.timeout_ticks)
                    return 1'b0;
                if (sess_phase == SES_SYNC) begin
                    // Sync timeout ends the session without a reply code
                    sess_phase = SES_DONE;
                    r.finished = 1'b1;
                end else begin
                    abort_session(r);
                end
                return 1'b1;
            end
            OP_BYTE: begin
                if (sess_phase != SES_SYNC)
                    return 1'b0;
                sync_win = {it.rx_byte, sync_win[31:8]};
                if (sync_win != SYNC_PATTERN)
                    return 1'b0;
                idle_cnt        = '0;
                sess_phase      = SES_REQUEST;
                r.reply         = RPL_SYNCED;
                r.reply_payload = cfg_shadow.device_ident;
                return 1'b1;
            end
            OP_PKT: begin
                case (sess_phase)
                    SES_REQUEST: begin
                        if (it.pkt_length != cfg_shadow.request_len || it.pkt_is_data ||
                            it.pkt_first_byte != cfg_shadow.request_code) begin
                            abort_session(r);
                        end else begin
                            idle_cnt   = '0;
                            sess_phase = SES_SIZE;
                            r.reply    = RPL_ACK;
                        end
                        return 1'b1;
                    end
                    SES_SIZE: begin
                        if (it.pkt_length != cfg_shadow.size_pkt_len || it.pkt_is_data ||
                            it.pkt_first_byte != cfg_shadow.size_code ||
                            it.pkt_size_word > {8'h00, cfg_shadow.max_image_bytes}) begin
                            abort_session(r);
                        end else begin
                            image_len  = it.pkt_size_word[23:0];
                            idle_cnt   = '0;
                            sess_phase = SES_IV;
                            r.reply    = RPL_ACK;
                        end
                        return 1'b1;
                    end
                    SES_IV: begin
                        if (!it.pkt_is_data) begin
                            abort_session(r);
                        end else begin
                            r.reply        = RPL_ACK;
                            r.erase_app    = 1'b1;
                            r.load_iv      = 1'b1;
                            r.write_flash  = 1'b1;
                            r.write_offset = done_cnt;
                            r.write_length = it.pkt_length;
                            add_written(it.pkt_length);
                            sess_phase = SES_DATA;
                        end
                        return 1'b1;
                    end
                    SES_DATA: begin
                        if (!it.pkt_is_data) begin
                            abort_session(r);
                            return 1'b1;
                        end
                        offs = done_cnt;
                        add_written(it.pkt_length);
                        r.write_flash  = 1'b1;
                        r.decrypt      = 1'b1;
                        r.write_offset = offs;
                        r.write_length = it.pkt_length;
                        if (done_cnt < image_len) begin
                            r.reply = RPL_ACK;
                        end else begin
                            sess_phase = SES_DONE;
                            r.reply    = RPL_DONE;
                            r.finished = 1'b1;
                        end
                        return 1'b1;
                    end
                    // Packets are ignored while still waiting for sync
                    default: return 1'b0;
                endcase
            end
            default: return 1'b0;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking helpers
    // ------------------------------------------------------------------
    function automatic void flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
            flag_failure($sformatf("%s expected %0h, got %0h", field, want, got));
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    // Every field random, so that bits toggle even where the block ignores them
    function automatic t_in_item random_item(input t_op op);
        t_in_item it;
        it.op             = op;
        it.rx_byte        = 8'($urandom);
        it.pkt_is_data    = 1'($urandom);
        it.pkt_length     = 8'($urandom);
        it.pkt_first_byte = 8'($urandom);
        it.pkt_size_word  = $urandom;
        return it;
    endfunction

    function automatic t_in_item make_packet(input logic is_data, input logic [7:0] len,
                                             input logic [7:0] first,
                                             input logic [31:0] word);
        t_in_item it;
        it                = random_item(OP_PKT);
        it.pkt_is_data    = is_data;
        it.pkt_length     = len;
        it.pkt_first_byte = first;
        it.pkt_size_word  = word;
        return it;
    endfunction

    // Lean on the extremes: zero and all-ones come up far more than by chance
    function automatic logic [7:0] pick_byte_value();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it         = random_item(OP_BYTE);
        it.rx_byte = b;
        gen_win    = {b, gen_win[31:8]};
        items_to_send.push_back(it);
    endtask

    // Ticks, stray bytes and reserved ops between packets outside the sync phase
    task automatic push_side_items(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                items_to_send.push_back(random_item(OP_TICK));
                gen_ticks++;
            end else if (r == 1) begin
                items_to_send.push_back(random_item(OP_BYTE));
            end else begin
                items_to_send.push_back(random_item(OP_RESERVED));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Flow control of the run
    // ------------------------------------------------------------------
    // Hold until the queue, the input channel and the owed replies have stayed empty
    // on consecutive checks, so that items causing no reply have drained too
    task automatic wait_quiet();
        int quiet;
        quiet = 0;
        while (quiet < 4) begin
            @(posedge i_clk);
            if (items_to_send.size() != 0 || item_ch.valid || replies_due.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // Step to the next idling pattern once the driver has run dry
    task automatic rotate_idling();
        while (items_to_send.size() != 0)
            @(posedge i_clk);
        case (idle_mode)
            IDLE_NONE: begin
                idle_mode      = IDLE_SENDER;
                send_idle_pct  = 78;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                idle_mode      = IDLE_RECEIVER;
                send_idle_pct  = 0;
                recv_stall_pct = 78;
            end
            IDLE_RECEIVER: begin
                idle_mode      = IDLE_BOTH;
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
            default: begin
                idle_mode      = IDLE_NONE;
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Register write; only called while the block is quiet, so the shadow
    // can change at once
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TIMEOUT_TICKS: cfg_shadow.timeout_ticks   = val[15:0];
            CFG_MAX_IMAGE:     cfg_shadow.max_image_bytes = val[23:0];
            CFG_DEVICE_IDENT:  cfg_shadow.device_ident    = val[7:0];
            CFG_REQUEST_LEN:   cfg_shadow.request_len     = val[7:0];
            CFG_SIZE_PKT_LEN:  cfg_shadow.size_pkt_len    = val[7:0];
            CFG_REQUEST_CODE:  cfg_shadow.request_code    = val[7:0];
            CFG_SIZE_CODE:     cfg_shadow.size_code       = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop the timeout to at most a few ticks past the current idle count and tick
    // until it expires
    task automatic expire_timeout();
        wait_quiet();
        write_reg(CFG_TIMEOUT_TICKS, {8'($urandom), 16'($urandom_range(0, gen_ticks + 3))});
        repeat (6) items_to_send.push_back(random_item(OP_TICK));
    endtask

    // ------------------------------------------------------------------
    // Driver: take items from the queue, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        t_in_item  took;
        t_in_item  nxt;
        t_out_item want;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            cfg_shadow.timeout_ticks   = RST_TIMEOUT_TICKS;
            cfg_shadow.max_image_bytes = RST_MAX_IMAGE;
            cfg_shadow.device_ident    = RST_DEVICE_IDENT;
            cfg_shadow.request_len     = RST_REQUEST_LEN;
            cfg_shadow.size_pkt_len    = RST_SIZE_PKT_LEN;
            cfg_shadow.request_code    = RST_REQUEST_CODE;
            cfg_shadow.size_code       = RST_SIZE_CODE;
            sess_phase = SES_SYNC;
            sync_win   = '0;
            idle_cnt   = '0;
            image_len  = '0;
            done_cnt   = '0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                took.op             = item_ch.op;
                took.rx_byte        = item_ch.rx_byte;
                took.pkt_is_data    = item_ch.pkt_is_data;
                took.pkt_length     = item_ch.pkt_length;
                took.pkt_first_byte = item_ch.pkt_first_byte;
                took.pkt_size_word  = item_ch.pkt_size_word;
                accepted_count++;
                if (advance_session(took, want))
                    replies_due.push_back(want);
            end
            // Load a new item only when the slot is free; hold it otherwise
            if (!item_ch.valid || item_ch.ready) begin
                if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = items_to_send.pop_front();
                    item_ch.valid          <= 1'b1;
                    item_ch.op             <= nxt.op;
                    item_ch.rx_byte        <= nxt.rx_byte;
                    item_ch.pkt_is_data    <= nxt.pkt_is_data;
                    item_ch.pkt_length     <= nxt.pkt_length;
                    item_ch.pkt_first_byte <= nxt.pkt_first_byte;
                    item_ch.pkt_size_word  <= nxt.pkt_size_word;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each reply with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reply_monitor
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.reply         = res_ch.reply;
                got.reply_payload = res_ch.reply_payload;
                got.erase_app     = res_ch.erase_app;
                got.load_iv       = res_ch.load_iv;
                got.write_flash   = res_ch.write_flash;
                got.decrypt       = res_ch.decrypt;
                got.write_offset  = res_ch.write_offset;
                got.write_length  = res_ch.write_length;
                got.finished      = res_ch.finished;
                if (replies_due.size() == 0) begin
                    flag_failure($sformatf("unexpected reply %0h", got));
                end else begin
                    want = replies_due.pop_front();
                    compare_field("reply", want.reply, got.reply);
                    compare_field("reply_payload", want.reply_payload, got.reply_payload);
                    compare_field("erase_app", want.erase_app, got.erase_app);
                    compare_field("load_iv", want.load_iv, got.load_iv);
                    compare_field("write_flash", want.write_flash, got.write_flash);
                    compare_field("decrypt", want.decrypt, got.decrypt);
                    compare_field("write_offset", want.write_offset, got.write_offset);
                    compare_field("write_length", want.write_length, got.write_length);
                    compare_field("finished", want.finished, got.finished);
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake or a missing reply ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: one session per run, since only reset restarts the block
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_session_end finish_how;
        t_in_item     it;
        logic [23:0]  image_bytes;
        logic [23:0]  max_bytes;
        logic [24:0]  sent_total;
        logic [7:0]   b;
        logic [7:0]   len;
        int           r;
        int           iter;
        int           pkts;
        int           nack_at;
        bit           over;

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_TIMEOUT_TICKS;
        i_cfg_data             = '0;
        item_ch.valid          = 1'b0;
        item_ch.op             = OP_BYTE;
        item_ch.rx_byte        = '0;
        item_ch.pkt_is_data    = 1'b0;
        item_ch.pkt_length     = '0;
        item_ch.pkt_first_byte = '0;
        item_ch.pkt_size_word  = '0;
        res_ch.ready           = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pick how the session will end; a full download is the common case
        r = $urandom_range(0, 99);
        if (r < 50)      finish_how = END_DONE;
        else if (r < 65) finish_how = END_DATA_NACK;
        else if (r < 70) finish_how = END_IV_NACK;
        else if (r < 75) finish_how = END_SYNC_TIMEOUT;
        else if (r < 80) finish_how = END_REQ_TIMEOUT;
        else if (r < 87) finish_how = END_REQ_BAD;
        else if (r < 92) finish_how = END_SIZE_TIMEOUT;
        else             finish_how = END_SIZE_BAD;

        // Directed opening at reset configuration: reserved op, packets and ticks
        // while unsynced, byte extremes and partial sync patterns
        items_to_send.push_back(random_item(OP_RESERVED));
        items_to_send.push_back(make_packet(1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        items_to_send.push_back(make_packet(1'b1, 8'h00, 8'h00, 32'h0000_0000));
        repeat (3) begin
            items_to_send.push_back(random_item(OP_TICK));
            gen_ticks++;
        end
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_PATTERN[7:0]);
        send_byte(SYNC_PATTERN[15:8]);
        send_byte(SYNC_PATTERN[23:16]);
        send_byte(8'h00);
        send_byte(SYNC_PATTERN[7:0]);
        send_byte(SYNC_PATTERN[15:8]);
        wait_quiet();

        // Program the sync and request registers; keep the timeout well above the
        // ticks the noise below can carry
        write_reg(CFG_UNUSED, 24'($urandom));
        write_reg(CFG_TIMEOUT_TICKS, {8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(400, 65535))});
        write_reg(CFG_DEVICE_IDENT, {16'($urandom), pick_byte_value()});
        write_reg(CFG_REQUEST_LEN, {16'($urandom), pick_byte_value()});
        write_reg(CFG_REQUEST_CODE, {16'($urandom), pick_byte_value()});

        // Sync noise: bytes (some drawn from the pattern), ticks, ignored packets
        // and reserved ops; never let the window match by accident
        for (iter = 0; iter < 350; iter++) begin
            if (iter % 100 == 99)
                rotate_idling();
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if (r < 12)
                    b = 8'(SYNC_PATTERN >> (8 * $urandom_range(0, 3)));
                else
                    b = 8'($urandom);
                if ({b, gen_win[31:8]} == SYNC_PATTERN)
                    b = b ^ 8'h01;
                send_byte(b);
            end else if (r < 70) begin
                items_to_send.push_back(random_item(OP_TICK));
                gen_ticks++;
            end else if (r < 90) begin
                items_to_send.push_back(random_item(OP_PKT));
            end else begin
                items_to_send.push_back(random_item(OP_RESERVED));
            end
        end

        if (finish_how == END_SYNC_TIMEOUT) begin
            expire_timeout();
        end else begin
            for (iter = 0; iter < 4; iter++)
                send_byte(SYNC_PATTERN[8 * iter +: 8]);
            gen_ticks = 0;
            rotate_idling();
            push_side_items($urandom_range(0, 8));

            if (finish_how == END_REQ_TIMEOUT) begin
                expire_timeout();
            end else if (finish_how == END_REQ_BAD) begin
                // Break at least one of length, packet kind and opcode
                r = $urandom_range(1, 7);
                items_to_send.push_back(make_packet(
                    r[1],
                    cfg_shadow.request_len ^ (r[0] ? 8'($urandom_range(1, 255)) : 8'h00),
                    cfg_shadow.request_code ^ (r[2] ? 8'($urandom_range(1, 255)) : 8'h00),
                    $urandom));
            end else begin
                items_to_send.push_back(make_packet(1'b0, cfg_shadow.request_len,
                                                    cfg_shadow.request_code, $urandom));
                gen_ticks = 0;

                // Size phase registers: the image is sized for a long data phase,
                // now and then empty
                if ($urandom_range(0, 19) == 0)
                    image_bytes = '0;
                else
                    image_bytes = 24'($urandom_range(80000, 120000));
                r = $urandom_range(0, 9);
                if (r < 3)
                    max_bytes = 24'hFF_FFFF;
                else if (r < 5)
                    max_bytes = image_bytes;
                else
                    max_bytes = 24'($urandom_range(image_bytes, 24'hFF_FFFF));
                wait_quiet();
                write_reg(CFG_MAX_IMAGE, max_bytes);
                write_reg(CFG_SIZE_PKT_LEN, {16'($urandom), pick_byte_value()});
                write_reg(CFG_SIZE_CODE, {16'($urandom), pick_byte_value()});
                rotate_idling();
                push_side_items($urandom_range(0, 8));

                if (finish_how == END_SIZE_TIMEOUT) begin
                    expire_timeout();
                end else if (finish_how == END_SIZE_BAD) begin
                    it = make_packet(1'b0, cfg_shadow.size_pkt_len, cfg_shadow.size_code,
                                     {8'h00, image_bytes});
                    case ($urandom_range(0, 4))
                        0: it.pkt_length = it.pkt_length ^ 8'($urandom_range(1, 255));
                        1: it.pkt_is_data = 1'b1;
                        2: it.pkt_first_byte = it.pkt_first_byte ^ 8'($urandom_range(1, 255));
                        3: it.pkt_size_word = {8'h00, max_bytes} + 32'd1;
                        default: it.pkt_size_word = $urandom | 32'h0100_0000;
                    endcase
                    items_to_send.push_back(it);
                end else begin
                    items_to_send.push_back(make_packet(1'b0, cfg_shadow.size_pkt_len,
                                                        cfg_shadow.size_code,
                                                        {8'h00, image_bytes}));
                    push_side_items($urandom_range(0, 4));

                    if (finish_how == END_IV_NACK) begin
                        items_to_send.push_back(make_packet(1'b0, pick_length(),
                                                            8'($urandom), $urandom));
                    end else begin
                        // IV packet: its bytes count toward the running offset too
                        len = pick_length();
                        items_to_send.push_back(make_packet(1'b1, len, 8'($urandom),
                                                            $urandom));
                        sent_total = {17'd0, len};

                        // Data packets until the image is complete, or a control
                        // packet mid-stream when the run ends on a nack
                        nack_at = $urandom_range(1, 700);
                        pkts    = 0;
                        over    = 1'b0;
                        iter    = 0;
                        while (!over) begin
                            iter++;
                            if (iter % 100 == 0)
                                rotate_idling();
                            if ($urandom_range(0, 99) < 8) begin
                                push_side_items(1);
                            end else begin
                                pkts++;
                                if (finish_how == END_DATA_NACK && pkts == nack_at) begin
                                    items_to_send.push_back(make_packet(1'b0, pick_length(),
                                                                        8'($urandom),
                                                                        $urandom));
                                    over = 1'b1;
                                end else begin
                                    len = pick_length();
                                    items_to_send.push_back(make_packet(1'b1, len,
                                                                        8'($urandom),
                                                                        $urandom));
                                    sent_total = sent_total + {17'd0, len};
                                    over = (sent_total >= {1'b0, image_bytes});
                                end
                            end
                        end
                    end
                end
            end
        end

        // Session is over: everything from here on must be swallowed
        for (iter = 0; iter < 20; iter++)
            items_to_send.push_back(random_item(t_op'($urandom_range(0, 3))));
        wait_quiet();

        // Top short sessions up with more swallowed items to the planned run length
        for (iter = accepted_count; iter < ITEM_TARGET; iter++)
            items_to_send.push_back(random_item(t_op'($urandom_range(0, 3))));
        wait_quiet();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
